@@ hdl/ttfd_pkg.sv @@
// Package: shared types, codes and constants of the two-type frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package ttfd_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned KIND_W      = 3;
	localparam int unsigned CFG_IDX_W   = 8;

	localparam logic [BYTE_W-1:0] BINARY_PAYLOAD_BYTES = 8'd64;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
	localparam logic [BYTE_W-1:0] BIN_TYPE_RST    = 8'd1;
	localparam logic [BYTE_W-1:0] TXT_TYPE_RST    = 8'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_TYPE    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TXT_TYPE    = 8'd3;

	localparam logic [KIND_W-1:0] KIND_BIN     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_TXT     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_GOOD    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BAD     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TXTEND  = 3'd4;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
		logic [BYTE_W-1:0] binary_type_code;
		logic [BYTE_W-1:0] text_type_code;
	} cfg_t;

	typedef struct packed {
		logic              vld;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] byte_position;
		logic [KIND_W-1:0] item_kind;
	} res_t;

endpackage
`default_nettype wire

@@ hdl/ttfd_rx_if.sv @@
// Interface: received byte channel.
`timescale 1ns / 1ps
`default_nettype none
interface ttfd_rx_if import ttfd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ hdl/ttfd_res_if.sv @@
// Interface: result channel (payload bytes and end marks).
`timescale 1ns / 1ps
`default_nettype none
interface ttfd_res_if import ttfd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] payload_byte;
	logic [BYTE_W-1:0] byte_position;
	logic [KIND_W-1:0] item_kind;

	modport source (output valid, output payload_byte, output byte_position,
		output item_kind, input ready);
	modport sink   (input valid, input payload_byte, input byte_position,
		input item_kind, output ready);
endinterface
`default_nettype wire

@@ hdl/ttfd_cfg_if.sv @@
// Interface: configuration write channel.
`timescale 1ns / 1ps
`default_nettype none
interface ttfd_cfg_if import ttfd_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/two_type_frame_deframer_xor_unit.sv @@
// Top level: two-type sync-header frame deframer with XOR checksum.
//
// Usage:
//   rx  - one received byte per item (valid/ready).
//   res - payload bytes passed on as they arrive, plus one end mark per
//         binary or text frame (binary end with checksum verdict, or text end).
//   cfg - register writes (index 0..3: sync_first, sync_second,
//         binary_type_code, text_type_code); always ready, other indexes
//         are dropped. Write only while the block is idle.
// Path: an accepted byte passes the input register, then the result
//   register, which drives res.valid; a stall on res can hold it in the input register.
// Throughput: one byte per cycle while res is taken; header, type, length
//   and swallowed bytes give no result but still pass through the deframer.
// Reset: registers return to 0xAA, 0x55, 1, 2 and the deframer hunts for the
//   first header byte; the pipeline is emptied.
// Stall: when res is not taken, the result register holds and rx keeps
//   accepting until the input register is also full, then ready drops.
`timescale 1ns / 1ps
`default_nettype none
module two_type_frame_deframer_xor_unit import ttfd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ttfd_rx_if.sink     rx,
	ttfd_res_if.source  res,
	ttfd_cfg_if.sink    cfg
);

	cfg_t              cfg_cur;
	res_t              step_res;
	logic              byte_vld_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_vld_q;
	res_t              out_q;
	logic              out_free;
	logic              s1_fire;

	assign out_free = !out_vld_q || res.ready;
	assign s1_fire  = byte_vld_s1 && out_free;
	assign rx.ready = !byte_vld_s1 || out_free;

	ttfd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_cur)
	);

	ttfd_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (s1_fire),
		.rx_byte (byte_s1),
		.cfg     (cfg_cur),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			byte_vld_s1 <= 1'b0;
		else if (rx.ready)
			byte_vld_s1 <= rx.valid;
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid)
			byte_s1 <= rx.rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (out_free)
			out_vld_q <= s1_fire && step_res.vld;
	end

	always_ff @(posedge clk) begin
		if (s1_fire && step_res.vld)
			out_q <= step_res;
	end

	assign res.valid         = out_vld_q;
	assign res.payload_byte  = out_q.payload_byte;
	assign res.byte_position = out_q.byte_position;
	assign res.item_kind     = out_q.item_kind;

`ifndef SYNTHESIS
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (out_q.item_kind == KIND_GOOD || out_q.item_kind == KIND_BAD
		|| out_q.item_kind == KIND_TXTEND)) |-> (out_q.payload_byte == '0))
		else $error("end mark carries nonzero payload");

	a_bin_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.item_kind == KIND_BIN) |->
		(out_q.byte_position < BINARY_PAYLOAD_BYTES))
		else $error("binary byte position out of range");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (byte_vld_s1 && out_vld_q && !res.ready))
		else $error("input stalled without a full pipeline");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && step_res.vld) |=> out_vld_q)
		else $error("result lost between stages");
`endif

endmodule
`default_nettype wire

@@ hdl/ttfd_cfg_regs.sv @@
// Configuration register file: header bytes and type codes.
`timescale 1ns / 1ps
`default_nettype none
module ttfd_cfg_regs import ttfd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ttfd_cfg_if.sink  cfg,
	output cfg_t      cfg_out
);

	cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_out   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first       <= SYNC_FIRST_RST;
			cfg_q.sync_second      <= SYNC_SECOND_RST;
			cfg_q.binary_type_code <= BIN_TYPE_RST;
			cfg_q.text_type_code   <= TXT_TYPE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SYNC_FIRST:  cfg_q.sync_first       <= cfg.data;
				REG_SYNC_SECOND: cfg_q.sync_second      <= cfg.data;
				REG_BIN_TYPE:    cfg_q.binary_type_code <= cfg.data;
				REG_TXT_TYPE:    cfg_q.text_type_code   <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/ttfd_step.sv @@
// Deframer state machine: per-byte state update and result formation.
`timescale 1ns / 1ps
`default_nettype none
module ttfd_step import ttfd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire cfg_t              cfg,
	output res_t                   res
);

	localparam logic [2:0] PH_HUNT1   = 3'd0;
	localparam logic [2:0] PH_HUNT2   = 3'd1;
	localparam logic [2:0] PH_TYPE    = 3'd2;
	localparam logic [2:0] PH_BODY    = 3'd3;
	localparam logic [2:0] PH_TEXT    = 3'd4;
	localparam logic [2:0] PH_CHECK   = 3'd5;
	localparam logic [2:0] PH_TEXTEND = 3'd6;

	logic [2:0]        phase_q,  phase_d;
	logic [BYTE_W-1:0] ftype_q,  ftype_d;
	logic [BYTE_W-1:0] count_q,  count_d;
	logic [BYTE_W-1:0] tlen_q,   tlen_d;
	logic [BYTE_W-1:0] xor_q,    xor_d;
	logic [BYTE_W-1:0] count_inc;

	assign count_inc = count_q + 8'd1;

	always_comb begin
		phase_d = phase_q;
		ftype_d = ftype_q;
		count_d = count_q;
		tlen_d  = tlen_q;
		xor_d   = xor_q;
		res     = '0;
		case (phase_q)
			PH_HUNT2: begin
				phase_d = (rx_byte == cfg.sync_second) ? PH_TYPE : PH_HUNT1;
			end
			PH_TYPE: begin
				ftype_d = rx_byte;
				count_d = '0;
				xor_d   = '0;
				tlen_d  = '0;
				phase_d = PH_BODY;
			end
			PH_BODY: begin
				if (ftype_q == cfg.binary_type_code) begin
					res.vld           = 1'b1;
					res.payload_byte  = rx_byte;
					res.byte_position = count_q;
					res.item_kind     = KIND_BIN;
					xor_d             = xor_q ^ rx_byte;
					count_d           = count_inc;
					if (count_inc >= BINARY_PAYLOAD_BYTES)
						phase_d = PH_CHECK;
				end else if (ftype_q == cfg.text_type_code) begin
					tlen_d  = rx_byte;
					phase_d = PH_TEXT;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_TEXT: begin
				res.vld           = 1'b1;
				res.payload_byte  = rx_byte;
				res.byte_position = count_q;
				res.item_kind     = KIND_TXT;
				count_d           = count_inc;
				if (count_inc >= tlen_q)
					phase_d = PH_TEXTEND;
			end
			PH_CHECK: begin
				res.vld           = 1'b1;
				res.byte_position = count_q;
				res.item_kind     = (xor_q == rx_byte) ? KIND_GOOD : KIND_BAD;
				phase_d           = PH_HUNT1;
			end
			PH_TEXTEND: begin
				res.vld           = 1'b1;
				res.byte_position = count_q;
				res.item_kind     = KIND_TXTEND;
				phase_d           = PH_HUNT1;
			end
			default: begin
				phase_d = (rx_byte == cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			ftype_q <= '0;
			count_q <= '0;
			tlen_q  <= '0;
			xor_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			ftype_q <= ftype_d;
			count_q <= count_d;
			tlen_q  <= tlen_d;
			xor_q   <= xor_d;
		end
	end

endmodule
`default_nettype wire
